// File: rtl/bsc_pkg.sv
`default_nettype none
package bsc_pkg;

    // Default sizing of the tables
    localparam int MAX_PROCESSES = 16;
    localparam int MAX_RESOURCES = 8;
    localparam int UNIT_WIDTH    = 16;

    // Input item actions
    typedef enum logic [1:0] {
        ACT_LOAD_ENTRY = 2'd0,
        ACT_LOAD_AVAIL = 2'd1,
        ACT_REQUEST    = 2'd2
    } action_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_DENIED  = 2'd1,
        ST_UNSAFE  = 2'd2
    } status_t;

    // Configuration register indexes
    localparam logic CFG_PROCESSES = 1'b0;
    localparam logic CFG_RESOURCES = 1'b1;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_PID,
        S_CHK_RD,
        S_CHK_USE,
        S_CHK_END,
        S_APP_RD,
        S_APP_USE,
        S_SCAN,
        S_FIT_RD,
        S_FIT_USE,
        S_FIT_END,
        S_ADD_RD,
        S_ADD_USE,
        S_NEXT,
        S_RB_RD,
        S_RB_USE,
        S_DENY,
        S_UNSAFE,
        S_EMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    accept;
        logic    proc_to_pid;
        logic    proc_clr;
        logic    proc_inc;
        logic    res_clr;
        logic    res_inc;
        logic    chk;
        logic    apply;
        logic    fit;
        logic    miss_clr;
        logic    add;
        logic    finish;
        logic    rollback;
        logic    safe_init;
        logic    pass_init;
        logic    emit;
        status_t emit_status;
        logic    req_clr;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic start;
        logic pid_bad;
        logic fail;
        logic res_last;
        logic proc_last;
        logic proc_done;
        logic miss;
        logic all_done;
        logic found;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// File: rtl/bsc_ifs.sv
`default_nettype none
interface bsc_req_if #(
    parameter int PW  = 4,
    parameter int RIW = 3,
    parameter int UW  = 16
);
    logic           valid;
    logic           ready;
    logic [1:0]     action;
    logic [PW-1:0]  process;
    logic [RIW-1:0] resource;
    logic [UW-1:0]  allocated;
    logic [UW-1:0]  maximum;
    logic [UW-1:0]  amount;
    logic           final_element;

    modport source (output valid, action, process, resource, allocated, maximum, amount,
                    final_element, input ready);
    modport sink   (input valid, action, process, resource, allocated, maximum, amount,
                    final_element, output ready);
endinterface

interface bsc_rsp_if #(
    parameter int PW = 4
);
    logic          valid;
    logic          ready;
    logic [1:0]    status;
    logic [PW-1:0] sequence_process;
    logic [PW-1:0] sequence_position;
    logic          last;

    modport source (output valid, status, sequence_process, sequence_position, last,
                    input ready);
    modport sink   (input valid, status, sequence_process, sequence_position, last,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/bsc_ctrl.sv
`default_nettype none
module bsc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire bsc_pkg::sts_t sts,
    output bsc_pkg::cmd_t      cmd
);

    bsc_pkg::state_t state_reg;
    bsc_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bsc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence the check, apply, safety passes, rollback and result
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.emit_status = bsc_pkg::ST_GRANTED;
        in_ready        = 1'b0;
        case (state_reg)
            bsc_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (sts.start)
                begin
                    state_next = bsc_pkg::S_PID;
                end
            end
            bsc_pkg::S_PID:
            begin
                cmd.proc_to_pid = 1'b1;
                cmd.res_clr     = 1'b1;
                state_next      = sts.pid_bad ? bsc_pkg::S_DENY : bsc_pkg::S_CHK_RD;
            end
            bsc_pkg::S_CHK_RD:
            begin
                state_next = bsc_pkg::S_CHK_USE;
            end
            bsc_pkg::S_CHK_USE:
            begin
                cmd.chk = 1'b1;
                if (sts.res_last)
                begin
                    state_next = bsc_pkg::S_CHK_END;
                end
                else
                begin
                    cmd.res_inc = 1'b1;
                    state_next  = bsc_pkg::S_CHK_RD;
                end
            end
            bsc_pkg::S_CHK_END:
            begin
                cmd.res_clr = 1'b1;
                state_next  = sts.fail ? bsc_pkg::S_DENY : bsc_pkg::S_APP_RD;
            end
            bsc_pkg::S_APP_RD:
            begin
                state_next = bsc_pkg::S_APP_USE;
            end
            bsc_pkg::S_APP_USE:
            begin
                cmd.apply = 1'b1;
                if (sts.res_last)
                begin
                    cmd.safe_init = 1'b1;
                    cmd.proc_clr  = 1'b1;
                    state_next    = bsc_pkg::S_SCAN;
                end
                else
                begin
                    cmd.res_inc = 1'b1;
                    state_next  = bsc_pkg::S_APP_RD;
                end
            end
            bsc_pkg::S_SCAN:
            begin
                cmd.res_clr  = 1'b1;
                cmd.miss_clr = 1'b1;
                state_next   = sts.proc_done ? bsc_pkg::S_NEXT : bsc_pkg::S_FIT_RD;
            end
            bsc_pkg::S_FIT_RD:
            begin
                state_next = bsc_pkg::S_FIT_USE;
            end
            bsc_pkg::S_FIT_USE:
            begin
                cmd.fit = 1'b1;
                if (sts.res_last)
                begin
                    state_next = bsc_pkg::S_FIT_END;
                end
                else
                begin
                    cmd.res_inc = 1'b1;
                    state_next  = bsc_pkg::S_FIT_RD;
                end
            end
            bsc_pkg::S_FIT_END:
            begin
                cmd.res_clr = 1'b1;
                state_next  = sts.miss ? bsc_pkg::S_NEXT : bsc_pkg::S_ADD_RD;
            end
            bsc_pkg::S_ADD_RD:
            begin
                state_next = bsc_pkg::S_ADD_USE;
            end
            bsc_pkg::S_ADD_USE:
            begin
                cmd.add = 1'b1;
                if (sts.res_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = bsc_pkg::S_NEXT;
                end
                else
                begin
                    cmd.res_inc = 1'b1;
                    state_next  = bsc_pkg::S_ADD_RD;
                end
            end
            bsc_pkg::S_NEXT:
            begin
                if (!sts.proc_last)
                begin
                    cmd.proc_inc = 1'b1;
                    state_next   = bsc_pkg::S_SCAN;
                end
                else if (sts.all_done)
                begin
                    cmd.proc_clr = 1'b1;
                    state_next   = bsc_pkg::S_EMIT;
                end
                else if (!sts.found)
                begin
                    cmd.proc_to_pid = 1'b1;
                    cmd.res_clr     = 1'b1;
                    state_next      = bsc_pkg::S_RB_RD;
                end
                else
                begin
                    cmd.pass_init = 1'b1;
                    cmd.proc_clr  = 1'b1;
                    state_next    = bsc_pkg::S_SCAN;
                end
            end
            bsc_pkg::S_RB_RD:
            begin
                state_next = bsc_pkg::S_RB_USE;
            end
            bsc_pkg::S_RB_USE:
            begin
                cmd.rollback = 1'b1;
                if (sts.res_last)
                begin
                    state_next = bsc_pkg::S_UNSAFE;
                end
                else
                begin
                    cmd.res_inc = 1'b1;
                    state_next  = bsc_pkg::S_RB_RD;
                end
            end
            bsc_pkg::S_DENY:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = bsc_pkg::ST_DENIED;
                    cmd.req_clr     = 1'b1;
                    state_next      = bsc_pkg::S_IDLE;
                end
            end
            bsc_pkg::S_UNSAFE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = bsc_pkg::ST_UNSAFE;
                    cmd.req_clr     = 1'b1;
                    state_next      = bsc_pkg::S_IDLE;
                end
            end
            bsc_pkg::S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.proc_last)
                    begin
                        cmd.req_clr = 1'b1;
                        state_next  = bsc_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.proc_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = bsc_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/bsc_datapath.sv
`default_nettype none
module bsc_datapath #(
    parameter int MAX_PROCESSES = bsc_pkg::MAX_PROCESSES,
    parameter int MAX_RESOURCES = bsc_pkg::MAX_RESOURCES,
    parameter int UNIT_WIDTH    = bsc_pkg::UNIT_WIDTH,
    parameter int PW            = $clog2(MAX_PROCESSES),
    parameter int RIW           = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1,
    parameter int CW            = 5
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic            cfg_index,
    input  wire logic [CW-1:0]   cfg_data,
    input  wire logic [1:0]      in_action,
    input  wire logic [PW-1:0]   in_process,
    input  wire logic [RIW-1:0]  in_resource,
    input  wire logic [UNIT_WIDTH-1:0] in_allocated,
    input  wire logic [UNIT_WIDTH-1:0] in_maximum,
    input  wire logic [UNIT_WIDTH-1:0] in_amount,
    input  wire logic            in_final,
    input  wire bsc_pkg::cmd_t   cmd,
    output bsc_pkg::sts_t        sts,
    input  wire logic            out_ready,
    output logic                 out_valid,
    output logic [1:0]           out_status,
    output logic [PW-1:0]        out_process,
    output logic [PW-1:0]        out_position,
    output logic                 out_last
);

    localparam int UW    = UNIT_WIDTH;
    localparam int PCW   = $clog2(MAX_PROCESSES + 1);
    localparam int RCW   = $clog2(MAX_RESOURCES + 1);
    localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = UW + PCW;

    // Configuration registers
    logic [PCW-1:0] procs_reg;
    logic [RCW-1:0] res_use_reg;
    logic [PCW-1:0] n_use;
    logic [RCW-1:0] m_use;

    // Tables: one entry per process and resource
    logic [UW-1:0]    alloc_mem [DEPTH];
    logic [UW-1:0]    claim_mem [DEPTH];
    logic [DEPTH-1:0] ent_vld_reg;
    logic [UW-1:0]    rd_alloc_reg;
    logic [UW-1:0]    rd_claim_reg;
    logic             rd_vld_reg;

    // Vectors
    logic [UW-1:0] avail_reg [MAX_RESOURCES];
    logic [UW-1:0] req_reg   [MAX_RESOURCES];
    logic [WW-1:0] work_reg  [MAX_RESOURCES];

    // Safety check state
    logic [PW-1:0]            seq_mem [MAX_PROCESSES];
    logic [MAX_PROCESSES-1:0] fin_mask_reg;
    logic [PCW-1:0]           cnt_reg;
    logic                     found_reg;
    logic                     fail_reg;
    logic                     miss_reg;
    logic [PW-1:0]            pid_reg;
    logic [PW-1:0]            proc_cnt_reg;
    logic [RIW-1:0]           res_cnt_reg;

    // Output register
    logic          out_vld_reg;
    logic [1:0]    out_status_reg;
    logic [PW-1:0] out_proc_reg;
    logic [PW-1:0] out_pos_reg;
    logic          out_last_reg;

    logic          in_res_ok;
    logic          in_proc_ok;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] cur_addr;
    logic [UW-1:0] a_val;
    logic [UW-1:0] c_val;
    logic [UW-1:0] need;
    logic [UW-1:0] req_cur;
    logic [UW-1:0] avail_cur;
    logic [WW-1:0] work_cur;
    logic          load_entry;
    logic          load_avail;
    logic          load_req;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [UW-1:0] alloc_wd;
    logic [UW-1:0] claim_wd;
    logic          out_free;

    // Clamp the register values to the range from one to the table sizes
    always_comb
    begin
        if (procs_reg == '0)
        begin
            n_use = PCW'(1);
        end
        else if (procs_reg > PCW'(MAX_PROCESSES))
        begin
            n_use = PCW'(MAX_PROCESSES);
        end
        else
        begin
            n_use = procs_reg;
        end
        if (res_use_reg == '0)
        begin
            m_use = RCW'(1);
        end
        else if (res_use_reg > RCW'(MAX_RESOURCES))
        begin
            m_use = RCW'(MAX_RESOURCES);
        end
        else
        begin
            m_use = res_use_reg;
        end
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            procs_reg   <= PCW'(MAX_PROCESSES);
            res_use_reg <= RCW'(MAX_RESOURCES);
        end
        else if (cfg_we)
        begin
            if (cfg_index == bsc_pkg::CFG_PROCESSES)
            begin
                procs_reg <= cfg_data[PCW-1:0];
            end
            else
            begin
                res_use_reg <= cfg_data[RCW-1:0];
            end
        end
    end

    // Decode the accepted input item
    assign in_res_ok  = RCW'(in_resource) < RCW'(MAX_RESOURCES);
    assign in_proc_ok = PCW'(in_process) < PCW'(MAX_PROCESSES);
    assign in_addr    = AW'(AW'(in_process) * AW'(MAX_RESOURCES) + AW'(in_resource));
    assign cur_addr   = AW'(AW'(proc_cnt_reg) * AW'(MAX_RESOURCES) + AW'(res_cnt_reg));
    assign load_entry = cmd.accept && (in_action == bsc_pkg::ACT_LOAD_ENTRY)
                        && in_res_ok && in_proc_ok;
    assign load_avail = cmd.accept && (in_action == bsc_pkg::ACT_LOAD_AVAIL) && in_res_ok;
    assign load_req   = cmd.accept && (in_action == bsc_pkg::ACT_REQUEST);

    // Entries never written read as zero
    assign a_val     = rd_vld_reg ? rd_alloc_reg : '0;
    assign c_val     = rd_vld_reg ? rd_claim_reg : '0;
    assign need      = (c_val > a_val) ? (c_val - a_val) : '0;
    assign req_cur   = req_reg[res_cnt_reg];
    assign avail_cur = avail_reg[res_cnt_reg];
    assign work_cur  = work_reg[res_cnt_reg];

    // Select the table write: a load, the tentative grant, or its rollback
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        alloc_wd  = a_val + req_cur;
        claim_wd  = c_val;
        if (load_entry)
        begin
            mem_we    = 1'b1;
            mem_waddr = in_addr;
            alloc_wd  = in_allocated;
            claim_wd  = in_maximum;
        end
        else if (cmd.apply)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.rollback)
        begin
            mem_we   = 1'b1;
            alloc_wd = a_val - req_cur;
        end
    end

    // Write and read the tables
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            alloc_mem[mem_waddr] <= alloc_wd;
            claim_mem[mem_waddr] <= claim_wd;
        end
        rd_alloc_reg <= alloc_mem[cur_addr];
        rd_claim_reg <= claim_mem[cur_addr];
    end

    // Track written entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                ent_vld_reg[mem_waddr] <= 1'b1;
            end
            rd_vld_reg <= ent_vld_reg[cur_addr];
        end
    end

    // Update available, request and work vectors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_RESOURCES; i++)
            begin
                avail_reg[i] <= '0;
                req_reg[i]   <= '0;
                work_reg[i]  <= '0;
            end
        end
        else
        begin
            if (load_avail)
            begin
                avail_reg[in_resource] <= in_amount;
            end
            if (load_req && in_res_ok)
            begin
                req_reg[in_resource] <= in_amount;
            end
            if (cmd.req_clr)
            begin
                for (int i = 0; i < MAX_RESOURCES; i++)
                begin
                    req_reg[i] <= '0;
                end
            end
            if (cmd.apply)
            begin
                avail_reg[res_cnt_reg] <= avail_cur - req_cur;
                work_reg[res_cnt_reg]  <= WW'(avail_cur - req_cur);
            end
            if (cmd.rollback)
            begin
                avail_reg[res_cnt_reg] <= avail_cur + req_cur;
            end
            if (cmd.add)
            begin
                work_reg[res_cnt_reg] <= work_cur + WW'(a_val);
            end
        end
    end

    // Advance counters and safety bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pid_reg      <= '0;
            proc_cnt_reg <= '0;
            res_cnt_reg  <= '0;
            fin_mask_reg <= '0;
            cnt_reg      <= '0;
            found_reg    <= 1'b0;
            fail_reg     <= 1'b0;
            miss_reg     <= 1'b0;
        end
        else
        begin
            if (load_req)
            begin
                pid_reg <= in_process;
            end
            if (cmd.proc_to_pid)
            begin
                proc_cnt_reg <= pid_reg;
                fail_reg     <= 1'b0;
            end
            else if (cmd.proc_clr)
            begin
                proc_cnt_reg <= '0;
            end
            else if (cmd.proc_inc)
            begin
                proc_cnt_reg <= proc_cnt_reg + PW'(1);
            end
            if (cmd.res_clr)
            begin
                res_cnt_reg <= '0;
            end
            else if (cmd.res_inc)
            begin
                res_cnt_reg <= res_cnt_reg + RIW'(1);
            end
            if (cmd.chk && ((req_cur > need) || (req_cur > avail_cur)))
            begin
                fail_reg <= 1'b1;
            end
            if (cmd.miss_clr)
            begin
                miss_reg <= 1'b0;
            end
            else if (cmd.fit && (WW'(need) > work_cur))
            begin
                miss_reg <= 1'b1;
            end
            if (cmd.safe_init)
            begin
                fin_mask_reg <= '0;
                cnt_reg      <= '0;
                found_reg    <= 1'b0;
            end
            else if (cmd.pass_init)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.finish)
            begin
                fin_mask_reg[proc_cnt_reg] <= 1'b1;
                cnt_reg                    <= cnt_reg + PCW'(1);
                found_reg                  <= 1'b1;
            end
        end
    end

    // Record the safe sequence
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            seq_mem[cnt_reg[PW-1:0]] <= proc_cnt_reg;
        end
    end

    // Hold a result until it is taken
    assign out_free = !out_vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= cmd.emit_status;
            if (cmd.emit_status == bsc_pkg::ST_GRANTED)
            begin
                out_proc_reg <= seq_mem[proc_cnt_reg];
                out_pos_reg  <= proc_cnt_reg;
                out_last_reg <= (PCW'(proc_cnt_reg) == n_use - PCW'(1));
            end
            else
            begin
                out_proc_reg <= '0;
                out_pos_reg  <= '0;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign out_valid    = out_vld_reg;
    assign out_status   = out_status_reg;
    assign out_process  = out_proc_reg;
    assign out_position = out_pos_reg;
    assign out_last     = out_last_reg;

    // Report status to the controller
    always_comb
    begin
        sts.start     = load_req && in_final;
        sts.pid_bad   = PCW'(pid_reg) >= n_use;
        sts.fail      = fail_reg;
        sts.res_last  = RCW'(res_cnt_reg) == (m_use - RCW'(1));
        sts.proc_last = PCW'(proc_cnt_reg) == (n_use - PCW'(1));
        sts.proc_done = fin_mask_reg[proc_cnt_reg];
        sts.miss      = miss_reg;
        sts.all_done  = cnt_reg == n_use;
        sts.found     = found_reg;
        sts.out_free  = out_free;
    end

endmodule
`default_nettype wire

// File: rtl/bankers_safety_check.sv
// Load items (table entry, available amount, request element) are taken while idle.
// A final request element starts the check: the m resources are tested and applied,
// then up to n passes scan the unfinished processes, with a rollback if unsafe,
// where n and m are the processes and resources in use. Results leave one per cycle
// while rsp is ready; the next item is taken once the last is registered.
// Reset clears control state and marks every table entry unwritten (reads as zero).
`default_nettype none
module bankers_safety_check #(
    parameter int MAX_PROCESSES = bsc_pkg::MAX_PROCESSES,
    parameter int MAX_RESOURCES = bsc_pkg::MAX_RESOURCES,
    parameter int UNIT_WIDTH    = bsc_pkg::UNIT_WIDTH,
    parameter int PW            = $clog2(MAX_PROCESSES),
    parameter int RIW           = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1,
    parameter int CW            = ($clog2(MAX_PROCESSES + 1) > $clog2(MAX_RESOURCES + 1))
                                  ? $clog2(MAX_PROCESSES + 1) : $clog2(MAX_RESOURCES + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [CW-1:0] cfg_data,
    bsc_req_if.sink            req,
    bsc_rsp_if.source          rsp
);

    bsc_pkg::cmd_t cmd;
    bsc_pkg::sts_t sts;

    bsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bsc_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .UNIT_WIDTH    (UNIT_WIDTH),
        .PW            (PW),
        .RIW           (RIW),
        .CW            (CW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_action    (req.action),
        .in_process   (req.process),
        .in_resource  (req.resource),
        .in_allocated (req.allocated),
        .in_maximum   (req.maximum),
        .in_amount    (req.amount),
        .in_final     (req.final_element),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .out_status   (rsp.status),
        .out_process  (rsp.sequence_process),
        .out_position (rsp.sequence_position),
        .out_last     (rsp.last)
    );

endmodule
`default_nettype wire

// File: rtl/bsc_checker.sv
`default_nettype none
module bsc_checker #(
    parameter int PW = $clog2(bsc_pkg::MAX_PROCESSES)
) (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_ready,
    input wire logic [1:0]    in_action,
    input wire logic          in_final,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire logic [1:0]    out_status,
    input wire logic [PW-1:0] out_process,
    input wire logic [PW-1:0] out_position,
    input wire logic          out_last
);

    // A pending result stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A final request element blocks further input while the check runs
    a_busy_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_action == bsc_pkg::ACT_REQUEST) && in_final
        |=> !in_ready)
        else $error("input taken during a check");

    // Denied and unsafe results are single and final
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != bsc_pkg::ST_GRANTED) |-> out_last)
        else $error("rejection without last");

    // Denied and unsafe results carry a zero sequence entry
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != bsc_pkg::ST_GRANTED)
        |-> (out_process == '0) && (out_position == '0))
        else $error("rejection with sequence data");

endmodule

bind bankers_safety_check bsc_checker #(.PW(PW)) u_bsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .in_action    (req.action),
    .in_final     (req.final_element),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_status   (rsp.status),
    .out_process  (rsp.sequence_process),
    .out_position (rsp.sequence_position),
    .out_last     (rsp.last)
);
`default_nettype wire

// File: sim/bankers_safety_check_tb.sv
`default_nettype none
module bankers_safety_check_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  act;
        logic [3:0]  proc;
        logic [2:0]  res;
        logic [15:0] alloc;
        logic [15:0] maxc;
        logic [15:0] amt;
        logic        fin;
    } req_item_t;

    typedef struct {
        bsc_pkg::status_t status;
        logic [3:0]       seq_proc;
        logic [3:0]       seq_pos;
        logic             last;
    } grant_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [4:0] cfg_data;

    bsc_req_if #(.PW(4), .RIW(3), .UW(16)) req_ch ();
    bsc_rsp_if #(.PW(4)) rsp_ch ();

    bankers_safety_check u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Shadow state of the allocator
    logic [15:0] held_tab  [16][8];
    logic [15:0] claim_tab [16][8];
    logic [15:0] avail_vec [8];
    logic [15:0] req_buf   [8];
    logic [4:0]  procs_reg;
    logic [3:0]  res_reg;

    req_item_t     pending_reqs[$];
    grant_result_t expected_grants[$];
    req_item_t     cur_req;
    int            send_gap;
    int            recv_stall;
    bit            no_idle;
    int            errors;

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic longint need_of(int p, int r);
        return (claim_tab[p][r] > held_tab[p][r]) ? claim_tab[p][r] - held_tab[p][r] : 0;
    endfunction

    function automatic void push_grant(bsc_pkg::status_t st, int pr, int pos, bit lst);
        grant_result_t g;
        g.status   = st;
        g.seq_proc = pr[3:0];
        g.seq_pos  = pos[3:0];
        g.last     = lst;
        expected_grants.push_back(g);
    endfunction

    // Run the request check and safety passes, queue the results
    function automatic void evaluate_request(int pid);
        int     n;
        int     m;
        int     cnt;
        int     j;
        bit     found;
        bit     fits;
        bit     done_mask [16];
        int     order [16];
        longint work [8];
        n = (procs_reg < 1) ? 1 : (procs_reg > 16) ? 16 : procs_reg;
        m = (res_reg < 1) ? 1 : (res_reg > 8) ? 8 : res_reg;
        if (pid >= n) begin
            push_grant(bsc_pkg::ST_DENIED, 0, 0, 1'b1);
            return;
        end
        for (j = 0; j < m; j++) begin
            if (req_buf[j] > need_of(pid, j) || req_buf[j] > avail_vec[j]) begin
                push_grant(bsc_pkg::ST_DENIED, 0, 0, 1'b1);
                return;
            end
        end
        for (j = 0; j < m; j++) begin
            avail_vec[j] = avail_vec[j] - req_buf[j];
            held_tab[pid][j] = held_tab[pid][j] + req_buf[j];
            work[j] = avail_vec[j];
        end
        for (int i = 0; i < 16; i++) done_mask[i] = 1'b0;
        cnt = 0;
        while (cnt < n) begin
            found = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!done_mask[i]) begin
                    fits = 1'b1;
                    for (j = 0; j < m; j++)
                        if (need_of(i, j) > work[j]) fits = 1'b0;
                    if (fits) begin
                        for (j = 0; j < m; j++) work[j] += held_tab[i][j];
                        order[cnt] = i;
                        cnt++;
                        done_mask[i] = 1'b1;
                        found = 1'b1;
                    end
                end
            end
            if (!found) break;
        end
        if (cnt < n) begin
            for (j = 0; j < m; j++) begin
                avail_vec[j] = avail_vec[j] + req_buf[j];
                held_tab[pid][j] = held_tab[pid][j] - req_buf[j];
            end
            push_grant(bsc_pkg::ST_UNSAFE, 0, 0, 1'b1);
            return;
        end
        for (int i = 0; i < n; i++)
            push_grant(bsc_pkg::ST_GRANTED, order[i], i, i + 1 == n);
    endfunction

    // Apply one accepted item to the shadow state
    function automatic void predict_item(req_item_t it);
        if (it.act == bsc_pkg::ACT_LOAD_ENTRY) begin
            held_tab[it.proc][it.res]  = it.alloc;
            claim_tab[it.proc][it.res] = it.maxc;
        end else if (it.act == bsc_pkg::ACT_LOAD_AVAIL) begin
            avail_vec[it.res] = it.amt;
        end else if (it.act == bsc_pkg::ACT_REQUEST) begin
            req_buf[it.res] = it.amt;
            if (it.fin) begin
                evaluate_request(it.proc);
                for (int j = 0; j < 8; j++) req_buf[j] = '0;
            end
        end
    endfunction

    function automatic void queue_item(logic [1:0] a, int p, int r, int al, int mx, int am,
                                       bit f);
        req_item_t it;
        it.act   = a;
        it.proc  = p[3:0];
        it.res   = r[2:0];
        it.alloc = al[15:0];
        it.maxc  = mx[15:0];
        it.amt   = am[15:0];
        it.fin   = f;
        pending_reqs.push_back(it);
    endfunction

    function automatic void queue_noise();
        queue_item($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(0, 1));
    endfunction

    // Load the available vector for m resources
    function automatic void queue_avail(int m);
        for (int r = 0; r < m; r++)
            queue_item(bsc_pkg::ACT_LOAD_AVAIL, 0, r, 0, 0, $urandom_range(1, 8), 1'b0);
    endfunction

    // Fill the tables with small values for n processes and m resources, then load the available vector
    function automatic void queue_tables(int n, int m);
        int al;
        for (int p = 0; p < n; p++) begin
            for (int r = 0; r < m; r++) begin
                al = $urandom_range(0, 3);
                queue_item(bsc_pkg::ACT_LOAD_ENTRY, p, r, al, al + $urandom_range(0, 4), 0,
                           1'b0);
            end
        end
        queue_avail(m);
    endfunction

    function automatic void queue_request(int n, int m);
        int pid;
        pid = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
        for (int r = 0; r < m - 1; r++)
            if ($urandom_range(0, 2) != 0)
                queue_item(bsc_pkg::ACT_REQUEST, pid, r, 0, 0, $urandom_range(0, 2), 1'b0);
        queue_item(bsc_pkg::ACT_REQUEST, pid, $urandom_range(0, m - 1), 0, 0,
                   $urandom_range(0, 2), 1'b1);
    endfunction

    // Sample after the edge so the driver's updates are settled
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_grants.size() != 0)
            @(negedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_limits(int p, int r);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= bsc_pkg::CFG_PROCESSES;
        cfg_data  <= p[4:0];
        @(posedge clk);
        cfg_index <= bsc_pkg::CFG_RESOURCES;
        cfg_data  <= r[4:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        procs_reg = p[4:0];
        res_reg   = r[3:0];
    endtask

    task automatic random_phase(int p, int r, int requests);
        int n;
        int m;
        bit full_load;
        wait_idle();
        set_limits(p, r);
        n = (p[4:0] < 1) ? 1 : (p[4:0] > 16) ? 16 : p[4:0];
        m = (r[3:0] < 1) ? 1 : (r[3:0] > 8) ? 8 : r[3:0];
        // Large limits reuse whatever the tables hold and reload only the available vector
        full_load = (n * m <= 24);
        no_idle = ($urandom_range(0, 3) == 0);
        if (full_load)
            queue_tables(n, m);
        else
            queue_avail(m);
        for (int k = 0; k < requests; k++) begin
            if ($urandom_range(0, 7) == 0) queue_noise();
            if (full_load && $urandom_range(0, 11) == 0) queue_tables(n, m);
            queue_request(n, m);
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #50ms;
        $display("[bankers_safety_check] ERROR");
        $finish;
    end

    // Request driver
    always @(posedge clk)
    begin
        logic nxt_valid;
        if (rst_n)
        begin
            nxt_valid = req_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                predict_item(cur_req);
                nxt_valid = 1'b0;
                send_gap  = draw_wait();
            end
            if (!nxt_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    req_ch.action        <= cur_req.act;
                    req_ch.process       <= cur_req.proc;
                    req_ch.resource      <= cur_req.res;
                    req_ch.allocated     <= cur_req.alloc;
                    req_ch.maximum       <= cur_req.maxc;
                    req_ch.amount        <= cur_req.amt;
                    req_ch.final_element <= cur_req.fin;
                    nxt_valid = 1'b1;
                end
            end
            req_ch.valid <= nxt_valid;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        grant_result_t g;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result: status %0d proc %0d pos %0d last %0b",
                                 rsp_ch.status, rsp_ch.sequence_process,
                                 rsp_ch.sequence_position, rsp_ch.last);
                    errors++;
                end
                else
                begin
                    g = expected_grants.pop_front();
                    if (rsp_ch.status !== g.status || rsp_ch.sequence_process !== g.seq_proc ||
                        rsp_ch.sequence_position !== g.seq_pos || rsp_ch.last !== g.last)
                    begin
                        if (errors < 10)
                            $display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                     g.status, g.seq_proc, g.seq_pos, g.last,
                                     rsp_ch.status, rsp_ch.sequence_process,
                                     rsp_ch.sequence_position, rsp_ch.last);
                        errors++;
                    end
                end
                recv_stall = draw_wait();
            end
            else if (recv_stall > 0)
                recv_stall--;
            rsp_ch.ready <= (recv_stall == 0);
        end
    end

    // Stimulus
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = bsc_pkg::CFG_PROCESSES;
        cfg_data  = '0;
        req_ch.valid         = 1'b0;
        req_ch.action        = bsc_pkg::ACT_LOAD_ENTRY;
        req_ch.process       = '0;
        req_ch.resource      = '0;
        req_ch.allocated     = '0;
        req_ch.maximum       = '0;
        req_ch.amount        = '0;
        req_ch.final_element = 1'b0;
        rsp_ch.ready         = 1'b0;
        send_gap   = 0;
        recv_stall = 0;
        no_idle    = 1'b0;
        errors     = 0;
        procs_reg  = 5'd16;
        res_reg    = 4'd8;
        for (int p = 0; p < 16; p++)
            for (int r = 0; r < 8; r++)
            begin
                held_tab[p][r]  = '0;
                claim_tab[p][r] = '0;
            end
        for (int r = 0; r < 8; r++)
        begin
            avail_vec[r] = '0;
            req_buf[r]   = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with three processes and two resources
        set_limits(3, 2);
        queue_item(bsc_pkg::ACT_LOAD_ENTRY, 0, 0, 1, 3, 0, 1'b1);
        queue_item(bsc_pkg::ACT_LOAD_ENTRY, 0, 1, 0, 2, 0, 1'b0);
        queue_item(bsc_pkg::ACT_LOAD_ENTRY, 1, 0, 2, 4, 0, 1'b0);
        queue_item(bsc_pkg::ACT_LOAD_ENTRY, 1, 1, 1, 1, 0, 1'b0);
        queue_item(bsc_pkg::ACT_LOAD_ENTRY, 2, 0, 0, 1, 0, 1'b0);
        queue_item(bsc_pkg::ACT_LOAD_ENTRY, 2, 1, 0, 1, 0, 1'b0);
        queue_item(bsc_pkg::ACT_LOAD_AVAIL, 0, 0, 0, 0, 2, 1'b1);
        queue_item(bsc_pkg::ACT_LOAD_AVAIL, 0, 1, 0, 0, 2, 1'b0);
        // grant with a safe sequence
        queue_item(bsc_pkg::ACT_REQUEST, 0, 0, 0, 0, 1, 1'b0);
        queue_item(bsc_pkg::ACT_REQUEST, 0, 1, 0, 0, 0, 1'b1);
        // deny on need, on available, on absent process
        queue_item(bsc_pkg::ACT_REQUEST, 1, 0, 0, 0, 5, 1'b1);
        queue_item(bsc_pkg::ACT_REQUEST, 0, 1, 0, 0, 2, 1'b0);
        queue_item(bsc_pkg::ACT_REQUEST, 0, 0, 0, 0, 2, 1'b1);
        queue_item(bsc_pkg::ACT_REQUEST, 7, 0, 0, 0, 0, 1'b1);
        // unused action is dropped
        queue_item(2'd3, 15, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        // huge claim makes the system unsafe and forces rollback
        queue_item(bsc_pkg::ACT_LOAD_ENTRY, 2, 1, 0, 16'hFFFF, 0, 1'b0);
        queue_item(bsc_pkg::ACT_REQUEST, 0, 0, 0, 0, 1, 1'b1);
        // full-scale values
        queue_item(bsc_pkg::ACT_LOAD_ENTRY, 15, 7, 16'hFFFF, 16'hFFFF, 0, 1'b0);
        queue_item(bsc_pkg::ACT_LOAD_ENTRY, 2, 1, 0, 1, 0, 1'b0);
        queue_item(bsc_pkg::ACT_LOAD_ENTRY, 1, 0, 0, 16'hFFFF, 0, 1'b0);
        queue_item(bsc_pkg::ACT_LOAD_AVAIL, 0, 0, 0, 0, 16'hFFFF, 1'b0);
        queue_item(bsc_pkg::ACT_REQUEST, 1, 0, 0, 0, 16'hFFFF, 1'b1);
        // final element only: the rest of the buffer counts as zero
        queue_item(bsc_pkg::ACT_REQUEST, 2, 1, 0, 0, 0, 1'b1);

        // Random part over several limits, extremes among them
        random_phase(1, 1, 6);
        random_phase(4, 3, 4);
        random_phase(0, 0, 4);
        random_phase(2, 3, 5);
        random_phase(8, 2, 4);
        random_phase(31, 15, 3);

        wait_idle();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("[bankers_safety_check] OK");
        else
            $display("[bankers_safety_check] ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
rtl/bsc_pkg.sv
rtl/bsc_ifs.sv
rtl/bsc_ctrl.sv
rtl/bsc_datapath.sv
rtl/bankers_safety_check.sv
rtl/bsc_checker.sv
sim/bankers_safety_check_tb.sv
